// File: rtl/sirt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants for the radix text converter
// Symbol table layout, queue entry format, character codes and the
// reciprocal table used by the digit step.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int NUM_W       = 32;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS  = 32;
  localparam int NDIG_W      = 6;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // config register indexes
  localparam logic [1:0] REG_SYM_LOW  = 2'd0;
  localparam logic [1:0] REG_SYM_HIGH = 2'd1;
  localparam logic [1:0] REG_RADIX    = 2'd2;

  localparam logic [63:0]        SYM_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [63:0]        SYM_HIGH_RESET = 64'h0;
  localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;

  // entry 0 is the symbol for digit value 0
  typedef logic [MAX_SYMBOLS-1:0][7:0] sym_table_t;

  typedef struct packed {
    logic             ok;   // symbol set passed the check
    logic             neg;  // leading minus needed
    logic [NUM_W-1:0] mag;  // magnitude, 2^31 for the most negative value
  } item_t;

  // floor(2^32 / b); an underestimate of the quotient by at most one
  function automatic logic [NUM_W-1:0] radix_recip(input logic [RADIX_W-1:0] b);
    logic [NUM_W-1:0] r;
    unique case (b)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sirt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_front: input side
// Takes the number, checks the symbol set and forms the magnitude.
// ----------------------------------------------------------------------------
module sirt_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [sirt_pkg::NUM_W-1:0] number,
  input  sirt_pkg::sym_table_t          symbols,
  input  logic [sirt_pkg::RADIX_W-1:0]  radix,
  input  logic                          q_full,
  output logic                          q_push,
  output sirt_pkg::item_t               q_entry
);
  import sirt_pkg::*;

  logic             bad;
  logic [NUM_W-1:0] raw;

  // radix range, sign symbols and a full pairwise check of the active symbols
  always_comb begin
    bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (RADIX_W'(i) < radix) begin
        if (symbols[i] == CHAR_PLUS || symbols[i] == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (symbols[j] == symbols[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign raw      = NUM_W'(number);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // two's complement negate also covers the most negative value
  assign q_entry.ok  = !bad;
  assign q_entry.neg = raw[NUM_W-1];
  assign q_entry.mag = raw[NUM_W-1] ? (~raw + NUM_W'(1)) : raw;

endmodule

// File: rtl/sirt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_queue: small FIFO between the front and back parts
// Register based, head is visible without a pop.
// ----------------------------------------------------------------------------
module sirt_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sirt_pkg::item_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output sirt_pkg::item_t head
);
  import sirt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/sirt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_back: digit engine and character output
// Reciprocal multiply plus one correction per digit, digits kept on a
// LIFO shift stack, then emitted most significant first.
// ----------------------------------------------------------------------------
module sirt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  sirt_pkg::item_t              q_head,
  output logic                         q_pop,
  input  sirt_pkg::sym_table_t         symbols,
  input  logic [sirt_pkg::RADIX_W-1:0] radix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   character,
  output logic                         symbols_ok,
  output logic                         last
);
  import sirt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_FIX  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_BAD  = 3'd5;

  localparam int STACK_W = MAX_DIGITS * DIGIT_W;

  logic [2:0]           state;
  logic [NDIG_W-1:0]    ndig;
  logic                 neg;
  logic [NUM_W-1:0]     mag;
  logic [NUM_W-1:0]     q0;
  logic [STACK_W-1:0]   digits;

  logic                 out_free;
  logic                 load_out;
  logic [2*NUM_W-1:0]   prod;
  logic [NUM_W-1:0]     qb;
  logic [NUM_W-1:0]     rem_full;
  logic [RADIX_W-1:0]   rem0;
  logic                 over;
  logic [NUM_W-1:0]     q_fix;
  logic [RADIX_W-1:0]   d_fix;

  assign out_free = !out_valid || out_ready;
  assign load_out = out_free &&
                    ((state == ST_SIGN) || (state == ST_EMIT) || (state == ST_BAD));
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // quotient estimate, low by at most one
  assign prod     = mag * radix_recip(radix);
  assign qb       = q0 * NUM_W'(radix);
  assign rem_full = mag - qb;
  assign rem0     = rem_full[RADIX_W-1:0];  // below 2*radix
  assign over     = (rem0 >= radix);
  assign q_fix    = over ? (q0 + NUM_W'(1)) : q0;
  assign d_fix    = over ? (rem0 - radix) : rem0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ndig      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            ndig  <= '0;
            state <= q_head.ok ? ST_MUL : ST_BAD;
          end
        end
        ST_MUL: begin
          state <= ST_FIX;
        end
        ST_FIX: begin
          ndig <= ndig + NDIG_W'(1);
          if (q_fix != '0) begin
            state <= ST_MUL;
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ndig <= ndig - NDIG_W'(1);
            if (ndig == NDIG_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_BAD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          mag <= q_head.mag;
          neg <= q_head.neg;
        end
      end
      ST_MUL: begin
        q0 <= prod[2*NUM_W-1:NUM_W];
      end
      ST_FIX: begin
        mag    <= q_fix;
        digits <= {digits[STACK_W-DIGIT_W-1:0], d_fix[DIGIT_W-1:0]};
      end
      ST_SIGN: begin
        if (out_free) begin
          character  <= CHAR_MINUS;
          symbols_ok <= 1'b1;
          last       <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          character  <= symbols[digits[DIGIT_W-1:0]];
          symbols_ok <= 1'b1;
          last       <= (ndig == NDIG_W'(1));
          digits     <= {{DIGIT_W{1'b0}}, digits[STACK_W-1:DIGIT_W]};
        end
      end
      ST_BAD: begin
        if (out_free) begin
          character  <= 8'h00;
          symbols_ok <= 1'b0;
          last       <= 1'b1;
        end
      end
      default: begin
        mag <= mag;
      end
    endcase
  end

endmodule

// File: rtl/signed_integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text: signed integer to text in a set radix
// Writes a 32-bit signed number as characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, number): one transfer per number.
//  - Output channel (out_valid/out_ready, character, symbols_ok, last):
//    one transfer per character; last marks the end of a number's text.
//  - cfg_we/cfg_index/cfg_data write the symbol table (index 0, 1) and
//    the radix (index 2); write only while the block is idle.
//  - The symbol set is checked per number; a bad set (radix outside 2..16,
//    a '+' or '-' symbol, or a repeated symbol) gives one transfer with
//    character 0, symbols_ok 0 and last 1.
//  - Each digit in the back part is a 32x32 multiply by the reciprocal of
//    the radix (state MUL), then a one-step quotient correction (state FIX).
//  - A two-entry queue between front and back accepts numbers until it is
//    full while the back part works or the output is stalled.
//  - Reset (rst, synchronous) empties the queue, drops any pending
//    output and restores the low table "01234567", a zero high word and radix 10.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [63:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sirt_pkg::NUM_W-1:0] number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       character,
  output logic                             symbols_ok,
  output logic                             last
);
  import sirt_pkg::*;

  logic [63:0]        sym_low;
  logic [63:0]        sym_high;
  logic [RADIX_W-1:0] radix;
  sym_table_t         symbols;

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  // config registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_low  <= SYM_LOW_RESET;
      sym_high <= SYM_HIGH_RESET;
      radix    <= RADIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYM_LOW:  sym_low  <= cfg_data;
        REG_SYM_HIGH: sym_high <= cfg_data;
        REG_RADIX:    radix    <= cfg_data[RADIX_W-1:0];
        default:      radix    <= radix;
      endcase
    end
  end

  assign symbols = {sym_high, sym_low};

  // front: accept and classify
  sirt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .number   (number),
    .symbols  (symbols),
    .radix    (radix),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  sirt_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: digit generation and character output
  sirt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .symbols    (symbols),
    .radix      (radix),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .symbols_ok (symbols_ok),
    .last       (last)
  );

endmodule

// File: rtl/sirt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_checker: port-level assertions for the radix text converter
// Bound to the top level.
// ----------------------------------------------------------------------------
module sirt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] character,
  input logic       symbols_ok,
  input logic       last
);
  import sirt_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character)
      && $stable(symbols_ok) && $stable(last))
    else $error("stalled output changed");

  a_bad_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && !symbols_ok |-> last && (character == 8'h00))
    else $error("rejected set result malformed");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && symbols_ok && (character == CHAR_MINUS) |-> !last)
    else $error("minus sign ended a number");

endmodule

bind signed_integer_to_radix_text sirt_checker u_checker (.*);

// File: test/signed_integer_to_radix_text_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_test: self-checking bench for the radix text block
// Drives numbers through the valid/ready input and checks every character
// transfer against a built-in predictor that tracks the symbol table and radix.
// Covers a directed pass over the corner cases, then random symbol sets and
// numbers with random idling on both sides.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_test;
  import sirt_pkg::*;

  // Index 3 is not decoded by the block; a write there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // "89ABCDEF": completes the reset low word to a full hex digit set.
  localparam logic [63:0] SYM_HIGH_HEX = 64'h4645_4443_4241_3938;

  localparam int STALL_PCT     = 15;   // idle chance: per cycle on the output side, per number on the input side
  localparam int TAIL_CYCLES   = 150;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 21;

  // One character transfer as the block should present it.
  typedef struct packed {
    logic [7:0] character;
    logic       ok;
    logic       last;
  } text_char_t;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    cfg_we     = 1'b0;
  logic [1:0]              cfg_index  = REG_SYM_LOW;
  logic [63:0]             cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic signed [NUM_W-1:0] number     = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [7:0]              character;
  logic                    symbols_ok;
  logic                    last;

  // Copy of the block's registers, updated on the same edges the block sees.
  logic [63:0]        sym_low_q  = SYM_LOW_RESET;
  logic [63:0]        sym_high_q = SYM_HIGH_RESET;
  logic [RADIX_W-1:0] radix_q    = RADIX_RESET;

  // Characters still owed by the block, oldest first.
  text_char_t expected_text[$];

  int   errors        = 0;
  int   numbers_taken = 0;
  int   chars_seen    = 0;
  int   rejects_seen  = 0;
  int   settings_used = 0;
  logic steady        = 1'b0;  // when set, neither side idles

  signed_integer_to_radix_text dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .number     (number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .symbols_ok (symbols_ok),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Symbol for digit value k; entry 0 is the lowest byte of the low word.
  function automatic logic [7:0] symbol_for(input int k);
    sym_table_t t;
    t = {sym_high_q, sym_low_q};
    return t[k];
  endfunction

  // The set is usable only with 2..16 symbols in play, none of them a sign
  // character and no symbol repeated. A zero byte is an ordinary symbol.
  function automatic logic symbol_set_valid();
    logic [7:0] s;
    if (radix_q < 2 || radix_q > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < int'(radix_q); i++) begin
      s = symbol_for(i);
      if (s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
      for (int j = 0; j < i; j++)
        if (symbol_for(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the text owed for one accepted number.
  function automatic void predict_text(input logic [NUM_W-1:0] raw);
    logic [NUM_W-1:0] mag;
    logic [7:0]       digs[$];
    if (!symbol_set_valid()) begin
      expected_text.push_back(text_char_t'{8'h00, 1'b0, 1'b1});
      return;
    end
    // Two's complement negate; 0x80000000 stays 2^31 as an unsigned magnitude.
    mag = raw[NUM_W-1] ? (~raw + 1'b1) : raw;
    do begin
      digs.push_front(symbol_for(int'(mag % radix_q)));
      mag = mag / radix_q;
    end while (mag != 0);
    if (raw[NUM_W-1])
      expected_text.push_back(text_char_t'{CHAR_MINUS, 1'b1, 1'b0});
    foreach (digs[i])
      expected_text.push_back(text_char_t'{digs[i], 1'b1, i == digs.size() - 1});
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: register shadow, prediction on input transfers, and the
  // comparison on output transfers. Everything is sampled at the rising edge;
  // stimulus only moves on the falling edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    text_char_t want;
    if (rst) begin
      sym_low_q  = SYM_LOW_RESET;
      sym_high_q = SYM_HIGH_RESET;
      radix_q    = RADIX_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYM_LOW:  sym_low_q  = cfg_data;
          REG_SYM_HIGH: sym_high_q = cfg_data;
          REG_RADIX:    radix_q    = cfg_data[RADIX_W-1:0];
          default: ;  // spare index: ignored
        endcase
      end
      if (in_valid && in_ready) begin
        predict_text(number);
        numbers_taken++;
      end
      if (out_valid && out_ready) begin
        chars_seen++;
        if (!symbols_ok) rejects_seen++;
        if (expected_text.size() == 0) begin
          $error("unexpected transfer: character %h symbols_ok %b last %b",
                 character, symbols_ok, last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (character !== want.character) begin
            $error("character: expected %h, got %h", want.character, character);
            errors++;
          end
          if (symbols_ok !== want.ok) begin
            $error("symbols_ok: expected %b, got %b", want.ok, symbols_ok);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
          end
        end
      end
    end
  end

  // Receiver backpressure, off while a steady stretch runs.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks; all start and end on a falling edge.
  // --------------------------------------------------------------------------

  // One input transfer. Valid is lowered only when a gap is taken, so it is
  // never dropped and raised within the same step.
  task automatic send_number(input logic [NUM_W-1:0] n);
    int gap;
    gap = (!steady && $urandom_range(99) < STALL_PCT) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the input until every owed character has been taken. Every
  // number yields at least one character, so an empty queue means idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_text.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] low, input logic [63:0] high,
                           input logic [63:0] radix_word);
    write_reg(REG_SYM_LOW, low);
    write_reg(REG_SYM_HIGH, high);
    write_reg(REG_RADIX, radix_word);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset digits 8 and 9 are both zero bytes, so the set is a repeat.
  task automatic test_reset_table();
    send_number('0);
    wait_idle();
  endtask

  // Decimal: zero, unit values, both extremes and a signed two-digit value.
  task automatic test_decimal();
    configure(SYM_LOW_RESET, SYM_HIGH_HEX, 64'd10);
    send_number('0);
    send_number(32'd1);
    send_number(-32'sd1);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(-32'sd10);
    wait_idle();
  endtask

  // Widest and narrowest bases; radix 2 on the most negative value gives the
  // longest run the block can produce (minus sign plus 32 digits).
  task automatic test_hex_and_binary();
    configure(SYM_LOW_RESET, SYM_HIGH_HEX, 64'd16);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'hDEAD_BEEF);
    wait_idle();
    write_reg(REG_RADIX, 64'd2);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number('0);
    wait_idle();
  endtask

  // Each way a symbol set can be rejected, plus two sets that must pass:
  // a sign byte parked beyond the radix, and a zero byte as a digit.
  task automatic test_bad_symbol_sets();
    int bad_radix[4] = '{0, 1, 17, 31};
    foreach (bad_radix[i]) begin
      write_reg(REG_RADIX, 64'(bad_radix[i]));
      send_number(32'd5);
      wait_idle();
    end
    configure(64'h3736_3534_2B32_3130, SYM_HIGH_HEX, 64'd10);  // plus at digit 3
    send_number(32'd42);
    wait_idle();
    configure(SYM_LOW_RESET, 64'h4645_4443_4241_2D38, 64'd10);  // minus at digit 9
    send_number(32'd42);
    wait_idle();
    configure(SYM_LOW_RESET, 64'h4645_4443_4241_3038, 64'd10);  // digit 9 repeats 0
    send_number(32'd42);
    wait_idle();
    configure(SYM_LOW_RESET, 64'h4645_4443_422B_3938, 64'd10);  // plus unused
    send_number(32'd123);
    wait_idle();
    configure(64'h3736_3534_3332_3100, SYM_HIGH_HEX, 64'd10);   // zero byte digit
    send_number(32'd1000);
    wait_idle();
  endtask

  // Spare index must be ignored; only the low five bits of radix are kept.
  task automatic test_register_edges();
    write_reg(REG_SPARE, {$urandom, $urandom});
    send_number(-32'sd987);
    wait_idle();
    write_reg(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE3);  // keeps radix 3
    send_number(-32'sd100);
    wait_idle();
  endtask

  // Random phases: each picks a symbol set, mostly valid, then pushes a mix of
  // full-range, small, extreme and near-power-of-base numbers through it.
  task automatic test_random();
    sym_table_t       syms;
    logic [255:0]     taken;
    logic [7:0]       b;
    logic [4:0]       radix_wr;
    logic [NUM_W-1:0] n;
    longint           p;
    int               base;
    int               pos;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      steady = (ph == 4 || ph == 5);
      // first two phases pin the extremes of the base
      base = (ph == 0) ? 2 : (ph == 1) ? MAX_SYMBOLS : $urandom_range(2, MAX_SYMBOLS);
      radix_wr = 5'(base);
      taken = '0;
      taken[CHAR_PLUS]  = 1'b1;
      taken[CHAR_MINUS] = 1'b1;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        do b = 8'($urandom_range(255)); while (taken[b]);
        taken[b] = 1'b1;
        syms[i]  = b;
        // entries past the base are don't-care and may hold anything
        if (i >= base && $urandom_range(1)) syms[i] = 8'($urandom_range(255));
      end
      if (ph >= 2 && $urandom_range(99) < 25) begin
        case ($urandom_range(3))
          0: radix_wr = $urandom_range(1) ? 5'($urandom_range(1)) : 5'($urandom_range(17, 31));
          1: syms[$urandom_range(base - 1)] = CHAR_PLUS;
          2: syms[$urandom_range(base - 1)] = CHAR_MINUS;
          default: begin
            pos = $urandom_range(1, base - 1);
            syms[pos] = syms[$urandom_range(pos - 1)];
          end
        endcase
      end
      if ($urandom_range(1)) write_reg(REG_SPARE, {$urandom, $urandom});
      // junk above bit 4 of the radix word must be dropped by the block
      configure(syms[7:0], syms[15:8], {32'($urandom), 27'($urandom), radix_wr});
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(5))
          0, 1: n = $urandom;
          2: begin
            n = $urandom_range(0, 2 * base);
            if ($urandom_range(1)) n = -n;
          end
          3: begin
            case ($urandom_range(3))
              0: n = '0;
              1: n = 32'h7FFF_FFFF;
              2: n = 32'h8000_0000;
              default: n = '1;
            endcase
          end
          default: begin
            // near a power of the base: exercises digit-count rollover
            p = 1;
            repeat ($urandom_range(1, 31))
              if (p * base <= 64'sh8000_0000) p = p * base;
            n = NUM_W'(p + $urandom_range(2) - 1);
            if ($urandom_range(1)) n = -n;
          end
        endcase
        send_number(n);
      end
    end
    wait_idle();
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_table();
    test_decimal();
    test_hex_and_binary();
    test_bad_symbol_sets();
    test_register_edges();
    test_random();

    // Anything the block emits during the tail is flagged by the monitor.
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Converted %0d numbers into %0d character transfers across %0d symbol sets;",
             numbers_taken, chars_seen, settings_used);
    $display("%0d transfers flagged a rejected set, %0d mismatches.",
             rejects_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
